// ----- src/mcbpt_pkg.sv -----
package mcbpt_pkg;

    // Operation codes carried in the input tuser field.
    typedef enum logic [1:0] {
        FUNC_OPEN  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLOSE = 2'd3
    } func_t;

    // Result status codes carried in the output tuser field.
    localparam int STATUS_W = 3;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK    = 3'd0;
    localparam status_t STATUS_ERROR = 3'd1;
    localparam status_t STATUS_FULL  = 3'd2;
    localparam status_t STATUS_EMPTY = 3'd3;
    localparam status_t STATUS_EOS   = 3'd4;

    // Fixed field widths.
    localparam int FUNC_W     = 2;
    localparam int HANDLE_W   = 5;
    localparam int BYTE_W     = 8;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

endpackage

// ----- src/multi_channel_byte_pipe_table.sv -----
// Results: open, write and close give their result from S_EXEC, once the pipe record read is in;
// a read that returns a byte gives it from S_BYTE, through the byte store read port.
// Throughput: one item at a time; a new item is taken only back in S_IDLE, after the pipe record
// memory read and any byte store read (both synchronous-read memories) and any m_tready stall.
// Reset (rst_n, asynchronous, active low) frees all pipes and handles except the reserved
// ones; the record memory and byte store are not cleared and need no clearing pass.
module multi_channel_byte_pipe_table
    import mcbpt_pkg::*;
#(
    parameter int NUM_PIPES        = 8,
    parameter int BUFFER_DEPTH     = 256,
    parameter int RESERVED_HANDLES = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // handle[4:0], data_in[12:5], zero pad
    input  logic [FUNC_W-1:0]     s_tuser,   // func[1:0]
    input  logic                  s_tlast,   // last_of_write
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // data_out[7:0], read_end[12:8],
                                             // write_end[17:13], zero pad
    output logic [STATUS_W-1:0]   m_tuser,   // status[2:0]
    output logic                  m_tlast    // write_done
);

    localparam int TOTAL_HANDLES = 2 * NUM_PIPES + RESERVED_HANDLES;
    localparam int PIPE_W        = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int HIDX_W        = (TOTAL_HANDLES > 1) ? $clog2(TOTAL_HANDLES) : 1;
    localparam int CMP_W         = ((HIDX_W > HANDLE_W) ? HIDX_W : HANDLE_W) + 1;
    localparam int PTR_W         = $clog2(BUFFER_DEPTH);
    localparam int CNT_W         = $clog2(BUFFER_DEPTH + 1);
    localparam int STORE_DEPTH   = NUM_PIPES * BUFFER_DEPTH;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int PAD_W         = OUT_DATA_W - BYTE_W - 2 * HANDLE_W;

    typedef struct packed {
        logic              rd_open;
        logic              wr_open;
        logic [HIDX_W-1:0] rd_handle;
        logic [HIDX_W-1:0] wr_handle;
        logic [PTR_W-1:0]  head;
        logic [PTR_W-1:0]  tail;
        logic [CNT_W-1:0]  count;
    } rec_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_BYTE
    } state_t;

    // Control and result registers.
    state_t                state_reg, state_next;
    logic [NUM_PIPES-1:0]  busy_reg, busy_next;
    logic [TOTAL_HANDLES-1:0] used_reg, used_next;
    logic [PIPE_W-1:0]     map_reg [TOTAL_HANDLES];
    logic [PIPE_W-1:0]     map_next [TOTAL_HANDLES];
    func_t                 func_reg, func_next;
    logic [HIDX_W-1:0]     hidx_reg, hidx_next;
    logic [BYTE_W-1:0]     din_reg, din_next;
    logic                  last_reg, last_next;
    logic                  lk_ok_reg, lk_ok_next;
    logic [PIPE_W-1:0]     pipe_reg, pipe_next;
    logic [ADDR_W-1:0]     baddr_reg, baddr_next;
    logic                  ovalid_reg, ovalid_next;
    status_t               status_reg, status_next;
    logic [BYTE_W-1:0]     dout_reg, dout_next;
    logic [HANDLE_W-1:0]   rend_reg, rend_next;
    logic [HANDLE_W-1:0]   wend_reg, wend_next;
    logic                  wdone_reg, wdone_next;

    // Memories.
    rec_t                  rec_mem [NUM_PIPES];
    rec_t                  rec_rdata;
    rec_t                  rec_wdata;
    logic                  rec_we;
    logic [PIPE_W-1:0]     rec_waddr;
    logic [PIPE_W-1:0]     rec_raddr;
    logic [BYTE_W-1:0]     byte_mem [STORE_DEPTH];
    logic [BYTE_W-1:0]     byte_rdata;
    logic                  byte_we;
    logic [ADDR_W-1:0]     byte_waddr;
    logic [ADDR_W-1:0]     byte_raddr;

    // Input handle lookup against the handle table.
    logic [HANDLE_W-1:0]   in_handle;
    logic [CMP_W-1:0]      in_handle_w;
    logic [HIDX_W-1:0]     in_hidx;
    logic                  in_lk_ok;

    // Allocation search.
    logic                  p_found;
    logic [PIPE_W-1:0]     p_free;
    logic                  h1_found;
    logic                  h2_found;
    logic [HIDX_W-1:0]     h1_idx;
    logic [HIDX_W-1:0]     h2_idx;
    logic [CMP_W-1:0]      h1_w;
    logic [CMP_W-1:0]      h2_w;

    logic                  out_free;
    logic [ADDR_W-1:0]     pipe_base;
    rec_t                  rec_mod;

    assign in_handle   = s_tdata[HANDLE_W-1:0];
    assign in_handle_w = CMP_W'(in_handle);
    assign in_hidx     = in_handle_w[HIDX_W-1:0];
    assign in_lk_ok    = (in_handle_w >= CMP_W'(RESERVED_HANDLES))
                      && (in_handle_w < CMP_W'(TOTAL_HANDLES))
                      && used_reg[in_hidx];

    assign out_free  = !ovalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign pipe_base = ADDR_W'(ADDR_W'(pipe_reg) * ADDR_W'(BUFFER_DEPTH));
    assign h1_w      = CMP_W'(h1_idx);
    assign h2_w      = CMP_W'(h2_idx);

    // Lowest free pipe and the two lowest free handles.
    always_comb
    begin
        p_found  = 1'b0;
        p_free   = '0;
        h1_found = 1'b0;
        h1_idx   = '0;
        h2_found = 1'b0;
        h2_idx   = '0;
        for (int i = 0; i < NUM_PIPES; i++)
        begin
            if (!busy_reg[i] && !p_found)
            begin
                p_found = 1'b1;
                p_free  = PIPE_W'(i);
            end
        end
        for (int i = RESERVED_HANDLES; i < TOTAL_HANDLES; i++)
        begin
            if (!used_reg[i] && !h1_found)
            begin
                h1_found = 1'b1;
                h1_idx   = HIDX_W'(i);
            end
        end
        for (int i = RESERVED_HANDLES; i < TOTAL_HANDLES; i++)
        begin
            if (!used_reg[i] && (HIDX_W'(i) != h1_idx) && !h2_found)
            begin
                h2_found = 1'b1;
                h2_idx   = HIDX_W'(i);
            end
        end
    end

    // Next-state logic: read the pipe record, modify it and write it back.
    always_comb
    begin
        state_next  = state_reg;
        busy_next   = busy_reg;
        used_next   = used_reg;
        map_next    = map_reg;
        func_next   = func_reg;
        hidx_next   = hidx_reg;
        din_next    = din_reg;
        last_next   = last_reg;
        lk_ok_next  = lk_ok_reg;
        pipe_next   = pipe_reg;
        baddr_next  = baddr_reg;
        ovalid_next = ovalid_reg && !m_tready;
        status_next = status_reg;
        dout_next   = dout_reg;
        rend_next   = rend_reg;
        wend_next   = wend_reg;
        wdone_next  = wdone_reg;
        rec_we      = 1'b0;
        rec_waddr   = pipe_reg;
        rec_wdata   = rec_rdata;
        rec_mod     = rec_rdata;
        byte_we     = 1'b0;
        byte_waddr  = ADDR_W'(pipe_base + ADDR_W'(rec_rdata.tail));
        rec_raddr   = pipe_reg;
        byte_raddr  = baddr_reg;

        case (state_reg)
            S_IDLE:
            begin
                rec_raddr = map_reg[in_hidx];
                if (s_tvalid)
                begin
                    func_next  = func_t'(s_tuser);
                    hidx_next  = in_hidx;
                    din_next   = s_tdata[HANDLE_W +: BYTE_W];
                    last_next  = s_tlast;
                    lk_ok_next = in_lk_ok;
                    pipe_next  = map_reg[in_hidx];
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    status_next = STATUS_ERROR;
                    dout_next   = '0;
                    rend_next   = '0;
                    wend_next   = '0;
                    wdone_next  = 1'b0;
                    state_next  = S_IDLE;
                    case (func_reg)
                        FUNC_OPEN:
                        begin
                            if (p_found && h1_found && h2_found)
                            begin
                                busy_next[p_free]   = 1'b1;
                                used_next[h1_idx]   = 1'b1;
                                used_next[h2_idx]   = 1'b1;
                                map_next[h1_idx]    = p_free;
                                map_next[h2_idx]    = p_free;
                                rec_we              = 1'b1;
                                rec_waddr           = p_free;
                                rec_wdata.rd_open   = 1'b1;
                                rec_wdata.wr_open   = 1'b1;
                                rec_wdata.rd_handle = h1_idx;
                                rec_wdata.wr_handle = h2_idx;
                                rec_wdata.head      = '0;
                                rec_wdata.tail      = '0;
                                rec_wdata.count     = '0;
                                status_next         = STATUS_OK;
                                rend_next           = h1_w[HANDLE_W-1:0];
                                wend_next           = h2_w[HANDLE_W-1:0];
                            end
                        end

                        FUNC_WRITE:
                        begin
                            wdone_next = last_reg;
                            if (lk_ok_reg && rec_rdata.wr_open
                                && (rec_rdata.wr_handle == hidx_reg))
                            begin
                                if (rec_rdata.count == CNT_W'(BUFFER_DEPTH))
                                begin
                                    status_next = STATUS_FULL;
                                end
                                else
                                begin
                                    byte_we     = 1'b1;
                                    rec_we      = 1'b1;
                                    rec_mod.tail = (rec_rdata.tail == PTR_W'(BUFFER_DEPTH - 1))
                                                 ? '0 : PTR_W'(rec_rdata.tail + 1'b1);
                                    rec_mod.count = CNT_W'(rec_rdata.count + 1'b1);
                                    rec_wdata   = rec_mod;
                                    status_next = STATUS_OK;
                                end
                            end
                        end

                        FUNC_READ:
                        begin
                            if (lk_ok_reg && rec_rdata.rd_open
                                && (rec_rdata.rd_handle == hidx_reg))
                            begin
                                if (rec_rdata.count == '0)
                                begin
                                    status_next = rec_rdata.wr_open ? STATUS_EMPTY : STATUS_EOS;
                                end
                                else
                                begin
                                    // The byte comes back from the store next cycle.
                                    byte_raddr  = ADDR_W'(pipe_base + ADDR_W'(rec_rdata.head));
                                    baddr_next  = byte_raddr;
                                    rec_we      = 1'b1;
                                    rec_mod.head = (rec_rdata.head == PTR_W'(BUFFER_DEPTH - 1))
                                                 ? '0 : PTR_W'(rec_rdata.head + 1'b1);
                                    rec_mod.count = CNT_W'(rec_rdata.count - 1'b1);
                                    rec_wdata   = rec_mod;
                                    ovalid_next = ovalid_reg && !m_tready;
                                    state_next  = S_BYTE;
                                end
                            end
                        end

                        FUNC_CLOSE:
                        begin
                            if (lk_ok_reg)
                            begin
                                if (rec_rdata.rd_open && (rec_rdata.rd_handle == hidx_reg))
                                begin
                                    rec_mod.rd_open = 1'b0;
                                end
                                else if (rec_rdata.wr_open
                                         && (rec_rdata.wr_handle == hidx_reg))
                                begin
                                    rec_mod.wr_open = 1'b0;
                                end
                                used_next[hidx_reg] = 1'b0;
                                map_next[hidx_reg]  = '0;
                                if (!rec_mod.rd_open && !rec_mod.wr_open)
                                begin
                                    busy_next[pipe_reg] = 1'b0;
                                end
                                rec_we      = 1'b1;
                                rec_wdata   = rec_mod;
                                status_next = STATUS_OK;
                            end
                        end

                        default:
                        begin
                            status_next = STATUS_ERROR;
                        end
                    endcase
                end
            end

            S_BYTE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    status_next = STATUS_OK;
                    dout_next   = byte_rdata;
                    rend_next   = '0;
                    wend_next   = '0;
                    wdone_next  = 1'b0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, tables and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= '0;
            for (int i = 0; i < TOTAL_HANDLES; i++)
            begin
                used_reg[i] <= (i < RESERVED_HANDLES);
                map_reg[i]  <= '0;
            end
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            used_reg   <= used_next;
            map_reg    <= map_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        hidx_reg   <= hidx_next;
        din_reg    <= din_next;
        last_reg   <= last_next;
        lk_ok_reg  <= lk_ok_next;
        pipe_reg   <= pipe_next;
        baddr_reg  <= baddr_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
        rend_reg   <= rend_next;
        wend_reg   <= wend_next;
        wdone_reg  <= wdone_next;
    end

    // Pipe record memory.
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        rec_rdata <= rec_mem[rec_raddr];
    end

    // Byte store memory.
    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[byte_waddr] <= din_reg;
        end
        byte_rdata <= byte_mem[byte_raddr];
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = wdone_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, wend_reg, rend_reg, dout_reg};

endmodule

// ----- src/mcbpt_checker.sv -----
module mcbpt_checker
    import mcbpt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [FUNC_W-1:0]     s_tuser,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]   m_tuser,
    input logic                  m_tlast
);

    // A stalled result transfer keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // One item at a time: the block is busy in the cycle after it takes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // A failed operation carries no byte and no handles.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata == '0))
        else $error("non-zero payload on a failed operation");

    // A write result never carries new handles or a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata == '0))
        else $error("write result carries payload");

endmodule

bind multi_channel_byte_pipe_table mcbpt_checker u_mcbpt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
